@@ hdl/rttt_pkg.sv @@
// package for the round trip time tracker: result kinds, controller states, field widths
// no dependencies
package rttt_pkg;

  localparam int unsigned ID_W       = 8;
  localparam int unsigned NOW_W      = 48;
  localparam int unsigned DELAY_W    = 48;
  localparam int unsigned SUM_W      = 64;
  localparam int unsigned COUNT_W    = 32;
  localparam int unsigned EVICT_W    = 9;
  localparam int unsigned IN_DATA_W  = 64;
  localparam int unsigned OUT_DATA_W = 208;

  typedef enum logic [1:0] {
    KIND_SENT    = 2'd0,
    KIND_MATCH   = 2'd1,
    KIND_TIMEOUT = 2'd2,
    KIND_INVALID = 2'd3
  } kind_e;

  typedef enum logic [0:0] {
    FUNC_SEND = 1'b0,
    FUNC_RECV = 1'b1
  } func_e;

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_SCAN  = 6'b000100,
    ST_RECV  = 6'b001000,
    ST_ACC   = 6'b010000,
    ST_FIN   = 6'b100000
  } state_e;

endpackage

@@ hdl/rttt_ram.sv @@
// generic simple dual port ram, one write port and one read port with registered read data
// no dependencies
module rttt_ram #(
  parameter int unsigned WIDTH = 49,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/round_trip_time_tracker_core.sv @@
// round trip time tracker top level: controller, totals and output register
// depends on rttt_pkg and rttt_ram
//
// input items on s_axis: tuser is the function (0 send, 1 response), tdata carries
// the received id bytes and the current time in microseconds.
// result items on m_axis: tuser is the kind (sent, matched, timed out, invalid id),
// tdata carries the id bytes, the delay, the delay total, both counters and the evicted count.
// one result item per input item, in order.
// state lives in one ram of WINDOW entries, a busy bit above a send timestamp.
// a send scans from the next ring slot, one ram read per busy slot it evicts
// (at most WINDOW), and stamps the first free slot; a matched response reads and
// clears its slot, then adds the delay to the total; a timed out one only reads
// its slot; an invalid id skips the ram. the single ram read port and the delay
// add stage set these steps. after reset the ram busy bits are cleared, one entry
// a cycle, through all WINDOW entries, while s_axis_tready stays low.
// the finished result sits in an output register; the next item is taken while it
// waits, and the controller holds at its last step until m_axis_tready frees it.
module round_trip_time_tracker_core #(
  parameter int unsigned WINDOW    = 256,
  parameter int unsigned TIME_BITS = 48
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // id_high[7:0], id_low[15:8], now_us[63:16]
  input  logic [rttt_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // func[0]
  input  logic                             s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // out_id_high[7:0], out_id_low[15:8], delay_us[63:16], delay_sum_us[127:64],
  // sent_count[159:128], answered_count[191:160], evicted[200:192], zeros above
  output logic [rttt_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  // kind[1:0]
  output logic [1:0]                       m_axis_tuser
);

  import rttt_pkg::*;

  localparam int unsigned SLOT_W = $clog2(WINDOW);
  localparam int unsigned RAM_W  = TIME_BITS + 1;
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW - 1);
  localparam logic [63:0] MAX48 = 64'hFFFF_FFFF_FFFF;

  state_e                 state_q, state_d;
  logic [SLOT_W-1:0]      clr_q, clr_d;
  logic [SLOT_W-1:0]      next_slot_q, next_slot_d;
  logic [SLOT_W-1:0]      slot_q, slot_d;
  logic [TIME_BITS-1:0]   now_q, now_d;
  kind_e                  kind_q, kind_d;
  logic [EVICT_W-1:0]     ev_q, ev_d;
  logic [DELAY_W-1:0]     delay_q, delay_d;
  logic [SUM_W-1:0]       total_q, total_d;
  logic [COUNT_W-1:0]     sent_q, sent_d;
  logic [COUNT_W-1:0]     ans_q, ans_d;
  logic                   out_valid_q, out_valid_d;
  logic [1:0]             out_user_q, out_user_d;
  logic [OUT_DATA_W-1:0]  out_data_q, out_data_d;

  logic                   ram_we;
  logic [SLOT_W-1:0]      ram_waddr;
  logic [RAM_W-1:0]       ram_wdata;
  logic [SLOT_W-1:0]      ram_raddr;
  logic [RAM_W-1:0]       ram_rdata;

  logic                   in_fire;
  logic                   out_free;
  logic [ID_W-1:0]        in_id_high, in_id_low;
  logic [NOW_W-1:0]       in_now;
  logic [15:0]            dec_slot16;
  logic                   dec_invalid;
  logic [SLOT_W-1:0]      dec_slot;
  logic [SLOT_W-1:0]      slot_inc;
  logic                   rd_busy;
  logic [TIME_BITS-1:0]   rd_time;
  logic [TIME_BITS-1:0]   diff;
  logic [63:0]            diff64;
  logic [SUM_W:0]         sum_ext;
  logic [15:0]            slot16;
  logic [ID_W-1:0]        res_id_high, res_id_low;

  rttt_ram #(
    .WIDTH(RAM_W),
    .DEPTH(WINDOW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  assign in_id_high  = s_axis_tdata[7:0];
  assign in_id_low   = s_axis_tdata[15:8];
  assign in_now      = s_axis_tdata[63:16];
  assign dec_slot16  = {in_id_high - 8'd1, in_id_low - 8'd1};
  assign dec_invalid = (in_id_high == 8'd0) || (dec_slot16 >= 16'(WINDOW));
  assign dec_slot    = dec_slot16[SLOT_W-1:0];

  assign slot_inc = (slot_q == SLOT_LAST) ? '0 : slot_q + 1'b1;
  assign rd_busy  = ram_rdata[TIME_BITS];
  assign rd_time  = ram_rdata[TIME_BITS-1:0];
  assign diff     = now_q - rd_time;
  assign diff64   = 64'(diff);
  assign sum_ext  = {1'b0, total_q} + (SUM_W + 1)'(delay_q);

  assign slot16      = 16'(slot_q);
  assign res_id_high = (kind_q == KIND_INVALID) ? '0 : slot16[15:8] + 8'd1;
  assign res_id_low  = (kind_q == KIND_INVALID) ? '0 : slot16[7:0] + 8'd1;

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    next_slot_d = next_slot_q;
    slot_d      = slot_q;
    now_d       = now_q;
    kind_d      = kind_q;
    ev_d        = ev_q;
    delay_d     = delay_q;
    total_d     = total_q;
    sent_d      = sent_q;
    ans_d       = ans_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_user_d  = out_user_q;
    out_data_d  = out_data_q;
    ram_we      = 1'b0;
    ram_waddr   = slot_q;
    ram_wdata   = '0;
    ram_raddr   = slot_q;

    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        if (clr_q == SLOT_LAST) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (s_axis_tuser == FUNC_RECV) begin
          ram_raddr = dec_slot;
        end else begin
          ram_raddr = next_slot_q;
        end
        if (in_fire) begin
          now_d   = TIME_BITS'(64'(in_now));
          ev_d    = '0;
          delay_d = '0;
          if (s_axis_tuser == FUNC_SEND) begin
            slot_d  = next_slot_q;
            state_d = ST_SCAN;
          end else if (dec_invalid) begin
            kind_d  = KIND_INVALID;
            state_d = ST_FIN;
          end else begin
            slot_d  = dec_slot;
            state_d = ST_RECV;
          end
        end
      end
      ST_SCAN: begin
        ram_we    = 1'b1;
        ram_waddr = slot_q;
        if (rd_busy) begin
          ram_raddr = slot_inc;
          slot_d    = slot_inc;
          if (ev_q != '1) begin
            ev_d = ev_q + 1'b1;
          end
        end else begin
          ram_wdata   = {1'b1, now_q};
          next_slot_d = slot_inc;
          kind_d      = KIND_SENT;
          if (sent_q != '1) begin
            sent_d = sent_q + 1'b1;
          end
          state_d = ST_FIN;
        end
      end
      ST_RECV: begin
        if (rd_busy) begin
          ram_we    = 1'b1;
          ram_waddr = slot_q;
          kind_d    = KIND_MATCH;
          delay_d   = (diff64 > MAX48) ? DELAY_W'(MAX48) : diff64[DELAY_W-1:0];
          state_d   = ST_ACC;
        end else begin
          kind_d  = KIND_TIMEOUT;
          state_d = ST_FIN;
        end
      end
      ST_ACC: begin
        total_d = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
        if (ans_q != '1) begin
          ans_d = ans_q + 1'b1;
        end
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_user_d  = kind_q;
          out_data_d  = {7'd0, ev_q, ans_q, sent_q, total_q, delay_q,
                         res_id_low, res_id_high};
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      next_slot_q <= '0;
      total_q     <= '0;
      sent_q      <= '0;
      ans_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      next_slot_q <= next_slot_d;
      total_q     <= total_d;
      sent_q      <= sent_d;
      ans_q       <= ans_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q     <= slot_d;
    now_q      <= now_d;
    kind_q     <= kind_d;
    ev_q       <= ev_d;
    delay_q    <= delay_d;
    out_user_q <= out_user_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_user_q;
  assign m_axis_tdata  = out_data_q;

  a_ram_write_states : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ST_CLEAR || state_q == ST_SCAN || state_q == ST_RECV))
    else $error("ram written outside clear, scan or receive");

  a_out_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |=> (out_valid_q && $stable(out_data_q)))
    else $error("stalled result item changed or dropped");

  a_sent_no_delay : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_user_q == KIND_SENT) |-> (out_data_q[63:16] == '0))
    else $error("send result carries a delay");

  a_invalid_no_id : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_user_q == KIND_INVALID) |-> (out_data_q[15:0] == '0))
    else $error("invalid id result carries id bytes");

  a_scan_free_ends : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && !rd_busy) |=> (state_q == ST_FIN && kind_q == KIND_SENT))
    else $error("scan did not finish on a free slot");

endmodule

@@ sim/round_trip_time_tracker_core_test.sv @@
// self-checking testbench for round_trip_time_tracker_core: directed table, then random probe traffic
// keeps its own model of the slot ring and totals and compares every result item field by field
// depends on rttt_pkg and the round_trip_time_tracker_core rtl
module round_trip_time_tracker_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rttt_pkg::*;

  localparam int unsigned WINDOW      = 256;
  localparam int unsigned CLK_PERIOD  = 10;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned ITEMS_PHASE = 300;
  localparam int unsigned PRINT_MAX   = 25;
  localparam logic [NOW_W-1:0] T_MAX  = '1;

  typedef struct packed {
    func_e              func;
    logic [ID_W-1:0]    id_hi;
    logic [ID_W-1:0]    id_lo;
    logic [NOW_W-1:0]   now;
  } probe_item_t;

  typedef struct packed {
    kind_e              kind;
    logic [ID_W-1:0]    id_hi;
    logic [ID_W-1:0]    id_lo;
    logic [DELAY_W-1:0] delay;
    logic [SUM_W-1:0]   sum;
    logic [COUNT_W-1:0] sent;
    logic [COUNT_W-1:0] answered;
    logic [EVICT_W-1:0] evicted;
  } probe_result_t;

  typedef struct packed {
    bit            typed;
    probe_item_t   item;
    probe_result_t res;
  } probe_row_t;

  localparam probe_result_t NO_RES = '0;
  localparam int unsigned DIR_ROWS = 21;
  localparam probe_row_t DIRECTED_ROWS [DIR_ROWS] = '{
    '{1'b1, '{FUNC_RECV, 8'h00, 8'h00, 48'h0},
      '{KIND_INVALID, 8'h00, 8'h00, 48'h0, 64'h0, 32'd0, 32'd0, 9'd0}},
    '{1'b1, '{FUNC_RECV, 8'h01, 8'h01, T_MAX},
      '{KIND_TIMEOUT, 8'h01, 8'h01, 48'h0, 64'h0, 32'd0, 32'd0, 9'd0}},
    '{1'b1, '{FUNC_RECV, 8'hFF, 8'hFF, 48'h0},
      '{KIND_INVALID, 8'h00, 8'h00, 48'h0, 64'h0, 32'd0, 32'd0, 9'd0}},
    '{1'b1, '{FUNC_RECV, 8'h02, 8'h01, 48'h0},
      '{KIND_INVALID, 8'h00, 8'h00, 48'h0, 64'h0, 32'd0, 32'd0, 9'd0}},
    '{1'b1, '{FUNC_SEND, 8'h00, 8'h00, 48'h0},
      '{KIND_SENT, 8'h01, 8'h01, 48'h0, 64'h0, 32'd1, 32'd0, 9'd0}},
    '{1'b1, '{FUNC_RECV, 8'h01, 8'h01, T_MAX},
      '{KIND_MATCH, 8'h01, 8'h01, T_MAX, 64'h0000_FFFF_FFFF_FFFF, 32'd1, 32'd1, 9'd0}},
    '{1'b1, '{FUNC_SEND, 8'h00, 8'h00, T_MAX},
      '{KIND_SENT, 8'h01, 8'h02, 48'h0, 64'h0000_FFFF_FFFF_FFFF, 32'd2, 32'd1, 9'd0}},
    '{1'b1, '{FUNC_RECV, 8'h01, 8'h02, 48'h0},
      '{KIND_MATCH, 8'h01, 8'h02, 48'h1, 64'h0001_0000_0000_0000, 32'd2, 32'd2, 9'd0}},
    '{1'b1, '{FUNC_RECV, 8'h01, 8'h02, 48'h5},
      '{KIND_TIMEOUT, 8'h01, 8'h02, 48'h0, 64'h0001_0000_0000_0000, 32'd2, 32'd2, 9'd0}},
    '{1'b1, '{FUNC_RECV, 8'h01, 8'h00, 48'h7},
      '{KIND_TIMEOUT, 8'h01, 8'h00, 48'h0, 64'h0001_0000_0000_0000, 32'd2, 32'd2, 9'd0}},
    '{1'b1, '{FUNC_SEND, 8'hFF, 8'hFF, 48'h3039},
      '{KIND_SENT, 8'h01, 8'h03, 48'h0, 64'h0001_0000_0000_0000, 32'd3, 32'd2, 9'd0}},
    '{1'b1, '{FUNC_RECV, 8'h01, 8'h03, 48'h3039},
      '{KIND_MATCH, 8'h01, 8'h03, 48'h0, 64'h0001_0000_0000_0000, 32'd3, 32'd3, 9'd0}},
    '{1'b0, '{FUNC_SEND, 8'hAA, 8'h55, 48'h64}, NO_RES},
    '{1'b0, '{FUNC_SEND, 8'h55, 8'hAA, 48'hFFFF_FFFF_FF00}, NO_RES},
    '{1'b0, '{FUNC_RECV, 8'h01, 8'h04, 48'hAAAA_AAAA_AAAA}, NO_RES},
    '{1'b0, '{FUNC_RECV, 8'h00, 8'hFF, 48'h0}, NO_RES},
    '{1'b0, '{FUNC_RECV, 8'hFF, 8'h00, T_MAX}, NO_RES},
    '{1'b0, '{FUNC_RECV, 8'h01, 8'h05, 48'h5555_5555_5555}, NO_RES},
    '{1'b0, '{FUNC_SEND, 8'h00, 8'h00, 48'h1}, NO_RES},
    '{1'b0, '{FUNC_RECV, 8'h01, 8'h06, 48'h0}, NO_RES},
    '{1'b0, '{FUNC_RECV, 8'h01, 8'h07, 48'h0}, NO_RES}
  };

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_DATA_W-1:0]   s_axis_tdata = '0;
  logic                   s_axis_tuser = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  m_axis_tdata;
  logic [1:0]             m_axis_tuser;

  round_trip_time_tracker_core #(
    .WINDOW   (WINDOW),
    .TIME_BITS(NOW_W)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // model of the ring and totals
  logic [NOW_W-1:0]   send_stamp [WINDOW];
  bit                 slot_busy  [WINDOW];
  int unsigned        ring_ptr;
  logic [SUM_W-1:0]   delay_total;
  logic [COUNT_W-1:0] sent_total;
  logic [COUNT_W-1:0] answered_total;

  probe_result_t expected_results [$];
  logic [NOW_W-1:0] clock_us;
  int unsigned src_idle_pct;
  int unsigned sink_idle_pct;
  int unsigned mismatches;
  int unsigned results_seen;
  int unsigned items_sent;
  int unsigned n_match, n_timeout, n_invalid;
  int unsigned evict_total, evict_max;
  int unsigned cycle_count;

  function automatic logic [2*ID_W-1:0] slot_id(input int unsigned slot);
    return {8'(slot / 256 + 1), 8'(slot + 1)};
  endfunction

  function automatic logic [NOW_W-1:0] rand48();
    return NOW_W'({$urandom, $urandom});
  endfunction

  function automatic probe_result_t track_probe(input probe_item_t it);
    probe_result_t r;
    int unsigned slot;
    int unsigned ev;
    logic [NOW_W-1:0] d;
    r = '0;
    ev = 0;
    if (it.func == FUNC_SEND) begin
      slot = ring_ptr;
      while (slot_busy[slot]) begin
        slot_busy[slot] = 1'b0;
        if (ev < 511) ev++;
        slot = (slot + 1) % WINDOW;
      end
      send_stamp[slot] = it.now;
      slot_busy[slot] = 1'b1;
      ring_ptr = (slot + 1) % WINDOW;
      if (sent_total != '1) sent_total++;
      r.kind = KIND_SENT;
      {r.id_hi, r.id_lo} = slot_id(slot);
      r.evicted = EVICT_W'(ev);
    end else begin
      slot = (int'(it.id_hi) - 1) * 256 + int'(8'(it.id_lo - 8'd1));
      if (it.id_hi == 8'd0 || slot >= WINDOW) begin
        r.kind = KIND_INVALID;
      end else if (!slot_busy[slot]) begin
        r.kind = KIND_TIMEOUT;
        {r.id_hi, r.id_lo} = slot_id(slot);
      end else begin
        d = it.now - send_stamp[slot];
        slot_busy[slot] = 1'b0;
        if (delay_total > 64'hFFFF_FFFF_FFFF_FFFF - SUM_W'(d)) delay_total = '1;
        else delay_total = delay_total + SUM_W'(d);
        if (answered_total != '1) answered_total++;
        r.kind = KIND_MATCH;
        {r.id_hi, r.id_lo} = slot_id(slot);
        r.delay = d;
      end
    end
    r.sum = delay_total;
    r.sent = sent_total;
    r.answered = answered_total;
    return r;
  endfunction

  // random probe traffic, mostly sends and responses to outstanding probes
  function automatic probe_item_t pick_probe();
    probe_item_t it;
    int unsigned r;
    int unsigned slot;
    int unsigned s;
    int unsigned busy_list [$];
    clock_us = clock_us + NOW_W'($urandom_range(5000, 1));
    it.func = FUNC_SEND;
    it.id_hi = 8'($urandom);
    it.id_lo = 8'($urandom);
    it.now = ($urandom_range(19) == 0) ? rand48() : clock_us;
    for (s = 0; s < WINDOW; s++) if (slot_busy[s]) busy_list.push_back(s);
    r = $urandom_range(99);
    if (r < 45 || (r < 80 && busy_list.size() == 0)) return it;
    it.func = FUNC_RECV;
    if (r < 80) begin
      slot = busy_list[$urandom_range(busy_list.size() - 1)];
      it.now = send_stamp[slot] +
               (($urandom_range(9) == 0) ? rand48() : NOW_W'($urandom_range(200000)));
      {it.id_hi, it.id_lo} = slot_id(slot);
    end else if (r < 88) begin
      slot = $urandom_range(WINDOW - 1);
      {it.id_hi, it.id_lo} = slot_id(slot);
    end else if (r < 95) begin
      it.id_hi = ($urandom_range(1) == 0) ? 8'h00 : 8'($urandom_range(255, 2));
    end else begin
      it.func = func_e'($urandom_range(1));
    end
    return it;
  endfunction

  task automatic push_item(input probe_item_t it, input bit typed, input probe_result_t typed_res);
    probe_result_t predicted;
    if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.func;
    s_axis_tdata  <= {it.now, it.id_lo, it.id_hi};
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = track_probe(it);
    expected_results.push_back(typed ? typed_res : predicted);
    items_sent++;
    case (predicted.kind)
      KIND_MATCH:   n_match++;
      KIND_TIMEOUT: n_timeout++;
      KIND_INVALID: n_invalid++;
      default: begin
        evict_total += 32'(predicted.evicted);
        if (32'(predicted.evicted) > evict_max) evict_max = 32'(predicted.evicted);
      end
    endcase
  endtask

  // answer every outstanding probe, fill the ring, then one more send clears it all
  task automatic wrap_full_ring();
    probe_item_t it;
    int unsigned s;
    for (s = 0; s < WINDOW; s++) begin
      if (slot_busy[s]) begin
        it.func = FUNC_RECV;
        {it.id_hi, it.id_lo} = slot_id(s);
        it.now = send_stamp[s] + NOW_W'($urandom_range(100000));
        push_item(it, 1'b0, NO_RES);
      end
    end
    repeat (WINDOW + 1) begin
      clock_us = clock_us + NOW_W'($urandom_range(50, 1));
      it.func = FUNC_SEND;
      it.id_hi = 8'($urandom);
      it.id_lo = 8'($urandom);
      it.now = clock_us;
      push_item(it, 1'b0, NO_RES);
    end
  endtask

  task automatic flag_mismatch(input string what, input logic [SUM_W-1:0] got,
                               input logic [SUM_W-1:0] want);
    if (mismatches < PRINT_MAX)
      $display("mismatch in result item %0d, %s: got %0h, expected %0h",
               results_seen, what, got, want);
    mismatches++;
  endtask

  task automatic check_result();
    probe_result_t want;
    results_seen++;
    if (expected_results.size() == 0) begin
      flag_mismatch("item with nothing expected", SUM_W'(m_axis_tuser), '0);
      return;
    end
    want = expected_results.pop_front();
    if (m_axis_tuser !== want.kind)
      flag_mismatch("kind", SUM_W'(m_axis_tuser), SUM_W'(want.kind));
    if (m_axis_tdata[7:0] !== want.id_hi)
      flag_mismatch("id high", SUM_W'(m_axis_tdata[7:0]), SUM_W'(want.id_hi));
    if (m_axis_tdata[15:8] !== want.id_lo)
      flag_mismatch("id low", SUM_W'(m_axis_tdata[15:8]), SUM_W'(want.id_lo));
    if (m_axis_tdata[63:16] !== want.delay)
      flag_mismatch("delay", SUM_W'(m_axis_tdata[63:16]), SUM_W'(want.delay));
    if (m_axis_tdata[127:64] !== want.sum)
      flag_mismatch("delay sum", m_axis_tdata[127:64], want.sum);
    if (m_axis_tdata[159:128] !== want.sent)
      flag_mismatch("sent count", SUM_W'(m_axis_tdata[159:128]), SUM_W'(want.sent));
    if (m_axis_tdata[191:160] !== want.answered)
      flag_mismatch("answered count", SUM_W'(m_axis_tdata[191:160]),
                    SUM_W'(want.answered));
    if (m_axis_tdata[200:192] !== want.evicted)
      flag_mismatch("evicted", SUM_W'(m_axis_tdata[200:192]), SUM_W'(want.evicted));
    if (m_axis_tdata[OUT_DATA_W-1:201] !== '0)
      flag_mismatch("padding", SUM_W'(m_axis_tdata[OUT_DATA_W-1:201]), '0);
  endtask

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) check_result();
    m_axis_tready <= rst_ni && (sink_idle_pct == 0 || $urandom_range(99) >= sink_idle_pct);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_results.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int unsigned row;
    int unsigned phase;
    probe_row_t cur;
    slot_busy = '{default: 1'b0};
    send_stamp = '{default: '0};
    ring_ptr = 0;
    delay_total = '0;
    sent_total = '0;
    answered_total = '0;
    clock_us = '0;
    items_sent = 0;
    n_match = 0;
    n_timeout = 0;
    n_invalid = 0;
    evict_total = 0;
    evict_max = 0;
    src_idle_pct = 8;
    sink_idle_pct = 58;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (row = 0; row < DIR_ROWS; row++) begin
      cur = DIRECTED_ROWS[row];
      push_item(cur.item, cur.typed, cur.res);
    end

    for (phase = 0; phase < 3; phase++) begin
      src_idle_pct  = (phase == 0) ? 8 : (phase == 1) ? 58 : 0;
      sink_idle_pct = (phase == 0) ? 58 : (phase == 1) ? 8 : 0;
      if (phase == 1) wrap_full_ring();
      repeat (ITEMS_PHASE) push_item(pick_probe(), 1'b0, NO_RES);
    end
    s_axis_tvalid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk_i);
    // longest send scan is a full window of slots
    repeat (WINDOW + 50) @(posedge clk_i);

    $display("%0d items driven, %0d result items checked, %0d mismatches",
             items_sent, results_seen, mismatches);
    $display("%0d matched, %0d timed out, %0d invalid ids, %0d slots evicted (%0d in one send)",
             n_match, n_timeout, n_invalid, evict_total, evict_max);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
